// ----- hdl/ssf_pkg.sv -----
// Shared types and constants of the six-value target-sum finder.
// No dependencies; every other file of the block imports this package.
package ssf_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValW        = 24;
  localparam int unsigned SumW        = 26;
  localparam int unsigned TgtW        = 27;

  typedef struct packed {
    logic [ValW-1:0] item_value;
    logic            is_last;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] first_value;
    logic [ValW-1:0] second_value;
    logic [ValW-1:0] third_value;
    logic [ValW-1:0] fourth_value;
    logic [ValW-1:0] fifth_value;
    logic [ValW-1:0] sixth_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SREAD, S_SCMP, S_SWR2, S_L0, S_L1, S_L2, S_L3, S_EVAL, S_FIN
  } state_e;

  typedef enum logic [1:0] {WR_IN, WR_RD0, WR_RD1} wr_sel_e;

  typedef enum logic [1:0] {CAP_NONE, CAP_IJ, CAP_KP, CAP_QR} cap_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     rd_en;
    cap_sel_e cap;
    logic     tgt_latch;
    logic     res_load;
    logic     res_found;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_gt;
    logic outer_over;
    logic inner_eq;
    logic inner_over;
  } stat_t;

endpackage

// ----- hdl/six_value_target_sum_finder_unit.sv -----
// Top level of the six-value target-sum finder: controller plus datapath.
// Depends on ssf_pkg, ssf_ctrl and ssf_datapath.
//
// Values load one per cycle while idle into a MaxItems-deep memory; the item
// flagged is_last starts a search and yields one result. The search first
// bubble-sorts the memory (one compare per read of an adjacent pair), then
// walks outer triples in index order and, for each, inner triples in index
// order until the inner sum reaches the complement; each candidate pair passes
// through S_L0, S_L1, S_L2, S_L3 and S_EVAL because the six values are fetched
// over the memory's two read ports. While a search runs no items are taken;
// items are accepted again while the result waits in its output register.
module six_value_target_sum_finder_unit import ssf_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [TgtW-1:0] cfg_data_i
);

  localparam int unsigned AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;

  assign cfg_ready_o = 1'b1;

  ssf_ctrl #(.MaxItems(MaxItems)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_i.is_last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .wr_addr_o   (wr_addr),
    .rd_addr0_o  (rd_addr0),
    .rd_addr1_o  (rd_addr1)
  );

  ssf_datapath #(.MaxItems(MaxItems)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .wr_addr_i   (wr_addr),
    .rd_addr0_i  (rd_addr0),
    .rd_addr1_i  (rd_addr1),
    .in_value_i  (in_i.item_value),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (out_o)
  );

  // a not-found result carries all-zero values
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.found |-> out_o.first_value == '0 && out_o.second_value == '0 &&
      out_o.third_value == '0 && out_o.fourth_value == '0 && out_o.fifth_value == '0 &&
      out_o.sixth_value == '0)
    else $error("not-found result with nonzero values");

  // once a result is posted the block is back to loading
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result posted while search still busy");

endmodule

// ----- hdl/ssf_datapath.sv -----
// Datapath: value memory, cached triple values, sum compares, target and result registers.
// Depends on ssf_pkg.
module ssf_datapath import ssf_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDef,
  localparam int unsigned AW = (MaxItems > 1) ? $clog2(MaxItems) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [AW-1:0]     rd_addr0_i,
  input  logic [AW-1:0]     rd_addr1_i,
  input  logic [ValW-1:0]   in_value_i,
  input  logic              cfg_valid_i,
  input  logic [TgtW-1:0]   cfg_data_i,
  output out_item_t         res_o
);

  logic [ValW-1:0] mem [MaxItems];
  logic [ValW-1:0] rd0_q, rd1_q, wr_data;
  logic [ValW-1:0] v_q [6];
  logic [TgtW-1:0] target_q, srch_q, comp;
  logic [SumW-1:0] outer, inner;
  out_item_t       res_q;

  // write data select
  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_RD0:  wr_data = rd0_q;
      WR_RD1:  wr_data = rd1_q;
      default: wr_data = in_value_i;
    endcase
  end

  // value memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= mem[rd_addr0_i];
      rd1_q <= mem[rd_addr1_i];
    end
  end

  // cached values i, j, k, p, q, r
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cap)
      CAP_IJ: begin
        v_q[0] <= rd0_q;
        v_q[1] <= rd1_q;
      end
      CAP_KP: begin
        v_q[2] <= rd0_q;
        v_q[3] <= rd1_q;
      end
      CAP_QR: begin
        v_q[4] <= rd0_q;
        v_q[5] <= rd1_q;
      end
      default: ;
    endcase
  end

  // config register and the target frozen for a search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tgt_latch) begin
      srch_q <= target_q;
    end
  end

  // triple sums and compares
  assign outer = SumW'(v_q[0]) + SumW'(v_q[1]) + SumW'(v_q[2]);
  assign inner = SumW'(v_q[3]) + SumW'(v_q[4]) + SumW'(v_q[5]);
  assign comp  = srch_q - TgtW'(outer);

  assign stat_o.rd_gt      = rd0_q > rd1_q;
  assign stat_o.outer_over = TgtW'(outer) > srch_q;
  assign stat_o.inner_eq   = TgtW'(inner) == comp;
  assign stat_o.inner_over = TgtW'(inner) > comp;

  // result register; all values zero when nothing found
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.found <= cmd_i.res_found;
      if (cmd_i.res_found) begin
        res_q.first_value  <= v_q[0];
        res_q.second_value <= v_q[1];
        res_q.third_value  <= v_q[2];
        res_q.fourth_value <= v_q[3];
        res_q.fifth_value  <= v_q[4];
        res_q.sixth_value  <= v_q[5];
      end else begin
        res_q.first_value  <= '0;
        res_q.second_value <= '0;
        res_q.third_value  <= '0;
        res_q.fourth_value <= '0;
        res_q.fifth_value  <= '0;
        res_q.sixth_value  <= '0;
      end
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/ssf_ctrl.sv -----
// Controller: load counter, bubble-sort sequencer and triple search walker.
// Depends on ssf_pkg.
module ssf_ctrl import ssf_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDef,
  localparam int unsigned AW = (MaxItems > 1) ? $clog2(MaxItems) : 1,
  localparam int unsigned CW = $clog2(MaxItems + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cmd_t          cmd_o,
  input  stat_t         stat_i,
  output logic [AW-1:0] wr_addr_o,
  output logic [AW-1:0] rd_addr0_o,
  output logic [AW-1:0] rd_addr1_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d;
  logic [AW-1:0] t_q, t_d;
  logic          swp_q, swp_d, fnd_q, fnd_d, ov_q, ov_d;
  logic [AW-1:0] i_q, j_q, k_q, p_q, q_q, r_q;
  logic [AW-1:0] i_d, j_d, k_d, p_d, q_d, r_d;
  logic [3*AW:0] adv_in, adv_out;
  logic [CW-1:0] t2;

  // next non-decreasing triple in lex order; from_c=0 skips the rest of c
  function automatic logic [3*AW:0] adv3(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                         input logic [AW-1:0] c, input logic from_c,
                                         input logic [CW-1:0] n);
    logic [CW-1:0] a1, b1, c1;
    logic [3*AW:0] res;
    a1 = CW'(a) + CW'(1);
    b1 = CW'(b) + CW'(1);
    c1 = CW'(c) + CW'(1);
    if (from_c && c1 < n) begin
      res = {1'b0, a, b, c1[AW-1:0]};
    end else if (b1 < n) begin
      res = {1'b0, a, b1[AW-1:0], b1[AW-1:0]};
    end else if (a1 < n) begin
      res = {1'b0, a1[AW-1:0], a1[AW-1:0], a1[AW-1:0]};
    end else begin
      res = {1'b1, a, b, c};
    end
    return res;
  endfunction

  assign adv_in  = adv3(p_q, q_q, r_q, !stat_i.inner_over, n_q);
  assign adv_out = adv3(i_q, j_q, k_q, !stat_i.outer_over, n_q);
  assign t2      = CW'(t_q) + CW'(2);

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    t_q   <= t_d;
    swp_q <= swp_d;
    fnd_q <= fnd_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    p_q   <= p_d;
    q_q   <= q_d;
    r_q   <= r_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    t_d        = t_q;
    swp_d      = swp_q;
    fnd_d      = fnd_q;
    ov_d       = ov_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    p_d        = p_q;
    q_d        = q_q;
    r_d        = r_q;
    cmd_o      = '{wr_en: 1'b0, wr_sel: WR_IN, rd_en: 1'b0, cap: CAP_NONE,
                   tgt_latch: 1'b0, res_load: 1'b0, res_found: 1'b0};
    wr_addr_o  = cnt_q[AW-1:0];
    rd_addr0_o = t_q;
    rd_addr1_o = AW'(CW'(t_q) + CW'(1));
    in_ready_o = 1'b0;

    // result transfer frees the output register
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CW'(MaxItems)) begin
            cmd_o.wr_en = 1'b1;
            cnt_d       = cnt_q + CW'(1);
          end
          if (in_last_i) begin
            n_d             = (cnt_q < CW'(MaxItems)) ? cnt_q + CW'(1) : cnt_q;
            cnt_d           = '0;
            cmd_o.tgt_latch = 1'b1;
            t_d             = '0;
            swp_d           = 1'b0;
            {i_d, j_d, k_d, p_d, q_d, r_d} = '0;
            state_d = (n_d < CW'(2)) ? S_L0 : S_SREAD;
          end
        end
      end
      S_SREAD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SCMP;
      end
      S_SCMP, S_SWR2: begin
        if (state_q == S_SCMP && stat_i.rd_gt) begin
          // lower slot takes the smaller value, upper slot follows
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_RD1;
          wr_addr_o    = t_q;
          state_d      = S_SWR2;
        end else begin
          if (state_q == S_SWR2) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_RD0;
            wr_addr_o    = AW'(CW'(t_q) + CW'(1));
            swp_d        = 1'b1;
          end
          if (t2 < n_q) begin
            t_d     = t_q + AW'(1);
            state_d = S_SREAD;
          end else if (swp_d) begin
            t_d     = '0;
            swp_d   = 1'b0;
            state_d = S_SREAD;
          end else begin
            state_d = S_L0;
          end
        end
      end
      S_L0: begin
        cmd_o.rd_en = 1'b1;
        rd_addr0_o  = i_q;
        rd_addr1_o  = j_q;
        state_d     = S_L1;
      end
      S_L1: begin
        cmd_o.cap   = CAP_IJ;
        cmd_o.rd_en = 1'b1;
        rd_addr0_o  = k_q;
        rd_addr1_o  = p_q;
        state_d     = S_L2;
      end
      S_L2: begin
        cmd_o.cap   = CAP_KP;
        cmd_o.rd_en = 1'b1;
        rd_addr0_o  = q_q;
        rd_addr1_o  = r_q;
        state_d     = S_L3;
      end
      S_L3: begin
        cmd_o.cap = CAP_QR;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        fnd_d = 1'b0;
        if (!stat_i.outer_over && stat_i.inner_eq) begin
          fnd_d   = 1'b1;
          state_d = S_FIN;
        end else if (!stat_i.outer_over && !adv_in[3*AW]) begin
          {p_d, q_d, r_d} = adv_in[3*AW-1:0];
          state_d         = S_L0;
        end else begin
          // outer triple exhausted or too large: next outer, inner restarts
          {i_d, j_d, k_d} = adv_out[3*AW-1:0];
          {p_d, q_d, r_d} = '0;
          state_d         = adv_out[3*AW] ? S_FIN : S_L0;
        end
      end
      S_FIN: begin
        if (!ov_q) begin
          cmd_o.res_load  = 1'b1;
          cmd_o.res_found = fnd_q;
          ov_d            = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule
